FILE: sv/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types, codes and helpers for the command history store.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int CHS_STORE_BYTES = 256;
  localparam int CHS_MAX_LINE    = 64;

  // request codes
  localparam logic [2:0] REQ_ADD        = 3'd0;
  localparam logic [2:0] REQ_GET        = 3'd1;
  localparam logic [2:0] REQ_STEP_PREV  = 3'd2;
  localparam logic [2:0] REQ_STEP_NEXT  = 3'd3;
  localparam logic [2:0] REQ_MATCH_PREV = 3'd4;
  localparam logic [2:0] REQ_MATCH_NEXT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_ALREADY = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_GET,
    OP_STEP,
    OP_MATCH,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic       handle_valid;
    logic [7:0] handle_pos;
    logic [7:0] skip_count;
    logic [6:0] length_limit;
    logic [7:0] step_count;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       result_handle_valid;
    logic [7:0] result_handle;
    logic [7:0] out_byte;
    logic [6:0] copied_count;
    logic       last_result;
  } out_t;

  typedef struct packed {
    op_t        op;
    logic       newer;
    logic       handle_valid;
    logic [7:0] handle_pos;
    logic [7:0] skip_count;
    logic [6:0] length_limit;
    logic [7:0] step_count;
  } cmd_t;

  // back end status towards the front end
  typedef struct packed {
    logic init_done;
    logic buf_done;
  } bk_stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

FILE: sv/chs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// chs_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module chs_cmd_fifo
  import chs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

FILE: sv/chs_front.sv
// ----------------------------------------------------------------------------
// chs_front
// Accepts request items, gathers line and pattern bytes into the line
// buffer and queues one command per complete request.
// ----------------------------------------------------------------------------
module chs_front
  import chs_pkg::*;
#(
  parameter int STORE_BYTES = CHS_STORE_BYTES,
  parameter int MAX_LINE    = CHS_MAX_LINE,
  localparam int LINE_CAP   = (MAX_LINE < STORE_BYTES - 2) ? MAX_LINE : STORE_BYTES - 2,
  localparam int LW         = $clog2(LINE_CAP + 1),
  localparam int LI         = $clog2(MAX_LINE)
)(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  input  bk_stat_t      bk_stat,
  input  logic          fifo_full,
  output logic          fifo_push,
  output cmd_t          fifo_data,
  output logic [LW-1:0] buf_len,
  input  logic [LI-1:0] lb_rd_addr,
  output logic [7:0]    lb_rd_data
);

  logic [7:0]    lb_mem [MAX_LINE];
  logic [7:0]    lb_rd_data_r;
  logic [LW-1:0] line_len_r;
  logic          lead_done_r;
  logic          busy_r;
  logic [LW-1:0] buf_len_r;

  logic          is_stream;
  logic          accept;
  logic          keep;
  logic          room;
  logic [LW-1:0] len_nxt;

  assign is_stream = (in_data.req_type == REQ_ADD) || (in_data.req_type == REQ_MATCH_PREV) ||
                     (in_data.req_type == REQ_MATCH_NEXT);
  // hold streaming bytes while the back end still reads the buffer
  assign in_stall  = !bk_stat.init_done || fifo_full || (is_stream && busy_r);
  assign accept    = in_valid && !in_stall;
  assign keep      = in_data.byte_valid && (in_data.data_byte != 8'd0) &&
                     !((in_data.req_type == REQ_ADD) && !lead_done_r &&
                       is_blank(in_data.data_byte));
  assign room      = (line_len_r < LW'(LINE_CAP));
  assign len_nxt   = (keep && room) ? line_len_r + 1'b1 : line_len_r;
  assign fifo_push = accept && (!is_stream || in_data.last);
  assign buf_len   = buf_len_r;
  assign lb_rd_data = lb_rd_data_r;

  always_comb begin
    fifo_data.newer        = 1'b0;
    fifo_data.handle_valid = in_data.handle_valid;
    fifo_data.handle_pos   = in_data.handle_pos;
    fifo_data.skip_count   = in_data.skip_count;
    fifo_data.length_limit = in_data.length_limit;
    fifo_data.step_count   = in_data.step_count;
    unique case (in_data.req_type)
      REQ_ADD:        fifo_data.op = OP_ADD;
      REQ_GET:        fifo_data.op = OP_GET;
      REQ_STEP_PREV:  fifo_data.op = OP_STEP;
      REQ_STEP_NEXT: begin
        fifo_data.op    = OP_STEP;
        fifo_data.newer = 1'b1;
      end
      REQ_MATCH_PREV: fifo_data.op = OP_MATCH;
      REQ_MATCH_NEXT: begin
        fifo_data.op    = OP_MATCH;
        fifo_data.newer = 1'b1;
      end
      default:        fifo_data.op = OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && is_stream && keep && room) begin
      lb_mem[LI'(line_len_r)] <= in_data.data_byte;
    end
    lb_rd_data_r <= lb_mem[lb_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      lead_done_r <= 1'b0;
      busy_r      <= 1'b0;
      buf_len_r   <= '0;
    end else begin
      if (bk_stat.buf_done) begin
        busy_r <= 1'b0;
      end
      if (accept && is_stream) begin
        if (in_data.last) begin
          line_len_r  <= '0;
          lead_done_r <= 1'b0;
          busy_r      <= 1'b1;
          buf_len_r   <= len_nxt;
        end else begin
          line_len_r <= len_nxt;
          if (keep) begin
            lead_done_r <= 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: sv/chs_back.sv
// ----------------------------------------------------------------------------
// chs_back
// Sequencer that owns the line store: clears it after reset, then runs
// add, get, step and match commands byte by byte and drives the results.
// ----------------------------------------------------------------------------
module chs_back
  import chs_pkg::*;
#(
  parameter int STORE_BYTES = CHS_STORE_BYTES,
  parameter int MAX_LINE    = CHS_MAX_LINE,
  localparam int LINE_CAP   = (MAX_LINE < STORE_BYTES - 2) ? MAX_LINE : STORE_BYTES - 2,
  localparam int LW         = $clog2(LINE_CAP + 1),
  localparam int LI         = $clog2(MAX_LINE),
  localparam int PW         = $clog2(STORE_BYTES),
  localparam int NW         = PW + 1
)(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fifo_empty,
  input  cmd_t          fifo_data,
  output logic          fifo_pop,
  input  logic [LW-1:0] buf_len,
  output logic [LI-1:0] lb_rd_addr,
  input  logic [7:0]    lb_rd_data,
  output bk_stat_t      bk_stat,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data
);

  typedef enum logic [5:0] {
    B_CLR, B_IDLE, B_EMIT,
    B_TRIM_CHK, B_TRIM_RD, B_TRIM_EV,
    B_OUT_RD, B_OUT_EV, B_IN_RD, B_IN_EV, B_SKIP_RD, B_SKIP_EV,
    B_SH_CHK, B_SH_RD, B_SH_EV,
    B_W_INIT, B_W_CHK, B_W_RD, B_W_EV, B_W_TERM, B_WP_RD, B_WP_EV,
    B_G_RD, B_G_EV, B_GS_RD, B_GS_EV, B_C_RD, B_C_EV, B_C_DEC,
    B_NB_RD, B_NB_EV, B_NB2_RD, B_NB2_EV,
    B_S_LOOP, B_S_AFTER,
    B_M_LOOP, B_M_AFTER, B_M_CHK, B_M_RD, B_M_EV
  } state_t;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    st_rd_data_r;
  logic [PW-1:0] st_rd_addr;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;

  state_t        state_r;
  state_t        emit_ret_r;
  state_t        nb_ret_r;
  cmd_t          cmd_r;
  out_t          res_r;
  out_t          out_data_r;
  logic          out_valid_r;
  logic [PW-1:0] head_r;
  logic [PW-1:0] p1_r;
  logic [PW-1:0] p2_r;
  logic [PW-1:0] res_h_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] guard_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] k_r;
  logic [LW-1:0] i_r;
  logic          entry_r;
  logic          ok_r;
  logic [7:0]    off_r;
  logic [6:0]    lim_r;
  logic [6:0]    cnt_r;
  logic [7:0]    num_r;
  logic [7:0]    cur_r;
  logic [7:0]    pend_r;
  logic          pend_v_r;

  logic [7:0]    b;
  logic          out_ready;
  logic          emit_fire;
  logic          n_lt;
  logic          h_out;
  logic [NW-1:0] sh_sum;
  logic [PW-1:0] sh_p2;
  logic          copyable;

  function automatic logic [PW-1:0] fwd1(input logic [PW-1:0] p);
    fwd1 = (p == PW'(STORE_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] back1(input logic [PW-1:0] p);
    back1 = (p == '0) ? PW'(STORE_BYTES - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] step1(input logic [PW-1:0] p, input logic newer);
    step1 = newer ? fwd1(p) : back1(p);
  endfunction

  function automatic out_t mk(input logic [1:0] s, input logic hv, input logic [PW-1:0] h,
                              input logic [7:0] ob, input logic [6:0] c, input logic l);
    out_t r;
    r.status              = s;
    r.result_handle_valid = hv;
    r.result_handle       = 8'(h);
    r.out_byte            = ob;
    r.copied_count        = c;
    r.last_result         = l;
    mk = r;
  endfunction

  assign b         = st_rd_data_r;
  assign out_ready = !out_valid_r || !out_stall;
  assign emit_fire = (state_r == B_EMIT) && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign fifo_pop  = (state_r == B_IDLE) && !fifo_empty;
  assign n_lt      = (n_r < NW'(STORE_BYTES));
  assign h_out     = (32'(fifo_data.handle_pos) >= STORE_BYTES);
  assign copyable  = (cnt_r < lim_r) && (cur_r != 8'd0);

  // start of the bytes after the removed entry, wrapped once
  assign sh_sum = {1'b0, fwd1(p1_r)} + NW'(len_r) + NW'(1);
  assign sh_p2  = (sh_sum >= NW'(STORE_BYTES)) ? PW'(sh_sum - NW'(STORE_BYTES)) : PW'(sh_sum);

  assign bk_stat.init_done = (state_r != B_CLR);
  assign bk_stat.buf_done  = emit_fire && res_r.last_result &&
                             ((cmd_r.op == OP_ADD) || (cmd_r.op == OP_MATCH));

  always_comb begin
    st_rd_addr = p1_r;
    lb_rd_addr = LI'(i_r);
    wr_en      = 1'b0;
    wr_addr    = p1_r;
    wr_data    = 8'd0;
    unique case (state_r)
      B_CLR: begin
        wr_en   = 1'b1;
        wr_addr = PW'(n_r);
      end
      B_TRIM_RD: lb_rd_addr = LI'(len_r - 1'b1);
      B_IN_RD:   lb_rd_addr = LI'(k_r - 1'b1);
      B_SH_RD:   st_rd_addr = p2_r;
      B_SH_EV: begin
        wr_en   = 1'b1;
        wr_data = b;
      end
      B_W_EV: begin
        wr_en   = 1'b1;
        wr_data = lb_rd_data;
      end
      B_W_TERM:  wr_en = 1'b1;
      B_WP_EV:   wr_en = (b != 8'd0) && n_lt;
      B_NB_RD:   st_rd_addr = p2_r;
      B_NB2_RD:  st_rd_addr = fwd1(p2_r);
      B_M_RD:    st_rd_addr = p2_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    st_rd_data_r <= mem[st_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit_fire) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLR;
      head_r   <= '0;
      n_r      <= '0;
      pend_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_CLR: begin
          n_r <= n_r + 1'b1;
          if (n_r == NW'(STORE_BYTES - 1)) begin
            state_r <= B_IDLE;
          end
        end

        B_IDLE: begin
          if (!fifo_empty) begin
            cmd_r    <= fifo_data;
            len_r    <= buf_len;
            guard_r  <= '0;
            off_r    <= fifo_data.skip_count;
            lim_r    <= (32'(fifo_data.length_limit) > MAX_LINE) ? 7'(MAX_LINE)
                                                                 : fifo_data.length_limit;
            cnt_r    <= '0;
            pend_v_r <= 1'b0;
            num_r    <= fifo_data.step_count;
            p1_r     <= fifo_data.handle_valid ? PW'(fifo_data.handle_pos) : back1(head_r);
            unique case (fifo_data.op)
              OP_ADD: state_r <= B_TRIM_CHK;
              OP_GET: begin
                p1_r <= PW'(fifo_data.handle_pos);
                if (!fifo_data.handle_valid || h_out) begin
                  res_r      <= mk(ST_INVALID, 1'b0, '0, 8'd0, 7'd0, 1'b1);
                  emit_ret_r <= B_IDLE;
                  state_r    <= B_EMIT;
                end else begin
                  state_r <= B_G_RD;
                end
              end
              OP_STEP, OP_MATCH: begin
                if (fifo_data.handle_valid && h_out) begin
                  res_r      <= mk(ST_INVALID, 1'b0, '0, 8'd0, 7'd0, 1'b1);
                  emit_ret_r <= B_IDLE;
                  state_r    <= B_EMIT;
                end else begin
                  state_r <= (fifo_data.op == OP_STEP) ? B_S_LOOP : B_M_LOOP;
                end
              end
              default: begin
                res_r      <= mk(ST_INVALID, 1'b0, '0, 8'd0, 7'd0, 1'b1);
                emit_ret_r <= B_IDLE;
                state_r    <= B_EMIT;
              end
            endcase
          end
        end

        B_EMIT: begin
          if (out_ready) begin
            state_r <= emit_ret_r;
          end
        end

        // drop trailing white space
        B_TRIM_CHK: begin
          if (len_r == '0) begin
            res_r      <= mk(ST_INVALID, 1'b0, '0, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end else begin
            state_r <= B_TRIM_RD;
          end
        end
        B_TRIM_RD: state_r <= B_TRIM_EV;
        B_TRIM_EV: begin
          if (is_blank(lb_rd_data)) begin
            len_r   <= len_r - 1'b1;
            state_r <= B_TRIM_CHK;
          end else begin
            p1_r    <= back1(back1(head_r));
            entry_r <= 1'b0;
            state_r <= B_OUT_RD;
          end
        end

        // walk entries from newest to oldest looking for a copy
        B_OUT_RD: state_r <= B_OUT_EV;
        B_OUT_EV: begin
          if (b == 8'd0 || guard_r >= NW'(STORE_BYTES)) begin
            p1_r    <= head_r;
            state_r <= B_W_INIT;
          end else begin
            k_r     <= len_r;
            state_r <= B_IN_RD;
          end
        end
        B_IN_RD: state_r <= B_IN_EV;
        B_IN_EV: begin
          if (k_r != '0 && b == lb_rd_data) begin
            k_r     <= k_r - 1'b1;
            p1_r    <= back1(p1_r);
            state_r <= B_IN_RD;
          end else if (k_r == '0 && b == 8'd0) begin
            if (!entry_r) begin
              res_r      <= mk(ST_ALREADY, 1'b0, '0, 8'd0, 7'd0, 1'b1);
              emit_ret_r <= B_IDLE;
              state_r    <= B_EMIT;
            end else begin
              p1_r    <= fwd1(p1_r);
              p2_r    <= sh_p2;
              n_r     <= '0;
              state_r <= B_SH_CHK;
            end
          end else begin
            p1_r <= back1(p1_r);
            if (b != 8'd0) begin
              n_r     <= NW'(1);
              state_r <= B_SKIP_RD;
            end else begin
              entry_r <= 1'b1;
              guard_r <= guard_r + 1'b1;
              state_r <= B_OUT_RD;
            end
          end
        end
        B_SKIP_RD: state_r <= B_SKIP_EV;
        B_SKIP_EV: begin
          p1_r <= back1(p1_r);
          if (b != 8'd0 && n_lt) begin
            n_r     <= n_r + 1'b1;
            state_r <= B_SKIP_RD;
          end else begin
            entry_r <= 1'b1;
            guard_r <= guard_r + 1'b1;
            state_r <= B_OUT_RD;
          end
        end

        // close the gap left by the removed entry
        B_SH_CHK: begin
          if (p2_r == head_r || !n_lt) begin
            state_r <= B_W_INIT;
          end else begin
            state_r <= B_SH_RD;
          end
        end
        B_SH_RD: state_r <= B_SH_EV;
        B_SH_EV: begin
          p1_r    <= fwd1(p1_r);
          p2_r    <= fwd1(p2_r);
          n_r     <= n_r + 1'b1;
          state_r <= B_SH_CHK;
        end

        // append the line, its terminator, then wipe the broken oldest entry
        B_W_INIT: begin
          res_h_r <= back1(p1_r);
          i_r     <= '0;
          state_r <= B_W_CHK;
        end
        B_W_CHK:  state_r <= (i_r == len_r) ? B_W_TERM : B_W_RD;
        B_W_RD:   state_r <= B_W_EV;
        B_W_EV: begin
          p1_r    <= fwd1(p1_r);
          i_r     <= i_r + 1'b1;
          state_r <= B_W_CHK;
        end
        B_W_TERM: begin
          p1_r    <= fwd1(p1_r);
          head_r  <= fwd1(p1_r);
          n_r     <= '0;
          state_r <= B_WP_RD;
        end
        B_WP_RD: state_r <= B_WP_EV;
        B_WP_EV: begin
          if (b != 8'd0 && n_lt) begin
            p1_r    <= fwd1(p1_r);
            n_r     <= n_r + 1'b1;
            state_r <= B_WP_RD;
          end else begin
            res_r      <= mk(ST_OK, 1'b1, res_h_r, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end
        end

        // get: check the handle, skip, then copy with one byte held back
        B_G_RD: state_r <= B_G_EV;
        B_G_EV: begin
          if (b != 8'd0) begin
            res_r      <= mk(ST_INVALID, 1'b0, '0, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end else begin
            p1_r    <= fwd1(p1_r);
            state_r <= B_GS_RD;
          end
        end
        B_GS_RD: state_r <= B_GS_EV;
        B_GS_EV: begin
          if (off_r != 8'd0) begin
            if (b != 8'd0) begin
              off_r   <= off_r - 1'b1;
              p1_r    <= fwd1(p1_r);
              state_r <= B_GS_RD;
            end else begin
              res_r      <= mk(ST_OK, 1'b0, '0, 8'd0, 7'd0, 1'b1);
              emit_ret_r <= B_IDLE;
              state_r    <= B_EMIT;
            end
          end else begin
            cur_r   <= b;
            state_r <= B_C_DEC;
          end
        end
        B_C_RD: state_r <= B_C_EV;
        B_C_EV: begin
          cur_r   <= b;
          state_r <= B_C_DEC;
        end
        B_C_DEC: begin
          if (copyable) begin
            pend_r   <= cur_r;
            pend_v_r <= 1'b1;
            cnt_r    <= cnt_r + 1'b1;
            p1_r     <= fwd1(p1_r);
            if (pend_v_r) begin
              res_r      <= mk(ST_OK, 1'b0, '0, pend_r, cnt_r, 1'b0);
              emit_ret_r <= B_C_RD;
              state_r    <= B_EMIT;
            end else begin
              state_r <= B_C_RD;
            end
          end else begin
            res_r      <= pend_v_r ? mk(ST_OK, 1'b0, '0, pend_r, cnt_r, 1'b1)
                                   : mk(ST_OK, 1'b0, '0, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end
        end

        // move p1 to the neighbouring entry terminator
        B_NB_RD: state_r <= B_NB_EV;
        B_NB_EV: begin
          if (b == 8'd0) begin
            if (n_r == '0) begin
              ok_r    <= 1'b0;
              state_r <= nb_ret_r;
            end else if (cmd_r.newer) begin
              state_r <= B_NB2_RD;
            end else begin
              p1_r    <= p2_r;
              ok_r    <= 1'b1;
              state_r <= nb_ret_r;
            end
          end else if (n_lt) begin
            p2_r    <= step1(p2_r, cmd_r.newer);
            n_r     <= n_r + 1'b1;
            state_r <= B_NB_RD;
          end else begin
            ok_r    <= 1'b0;
            state_r <= nb_ret_r;
          end
        end
        B_NB2_RD: state_r <= B_NB2_EV;
        B_NB2_EV: begin
          ok_r    <= (b != 8'd0);
          if (b != 8'd0) begin
            p1_r <= p2_r;
          end
          state_r <= nb_ret_r;
        end

        B_S_LOOP: begin
          if (num_r == 8'd0) begin
            res_r      <= mk(ST_OK, 1'b1, p1_r, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end else begin
            num_r    <= num_r - 1'b1;
            p2_r     <= step1(p1_r, cmd_r.newer);
            n_r      <= '0;
            nb_ret_r <= B_S_AFTER;
            state_r  <= B_NB_RD;
          end
        end
        B_S_AFTER: begin
          if (ok_r) begin
            state_r <= B_S_LOOP;
          end else begin
            res_r      <= mk(ST_NONE, 1'b0, '0, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end
        end

        B_M_LOOP: begin
          if (guard_r >= NW'(STORE_BYTES)) begin
            res_r      <= mk(ST_NONE, 1'b0, '0, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end else begin
            p2_r     <= step1(p1_r, cmd_r.newer);
            n_r      <= '0;
            nb_ret_r <= B_M_AFTER;
            state_r  <= B_NB_RD;
          end
        end
        B_M_AFTER: begin
          if (ok_r) begin
            p2_r    <= fwd1(p1_r);
            i_r     <= '0;
            state_r <= B_M_CHK;
          end else begin
            res_r      <= mk(ST_NONE, 1'b0, '0, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end
        end
        B_M_CHK: begin
          if (i_r == len_r) begin
            res_r      <= mk(ST_OK, 1'b1, p1_r, 8'd0, 7'd0, 1'b1);
            emit_ret_r <= B_IDLE;
            state_r    <= B_EMIT;
          end else begin
            state_r <= B_M_RD;
          end
        end
        B_M_RD: state_r <= B_M_EV;
        B_M_EV: begin
          if (b == lb_rd_data) begin
            i_r     <= i_r + 1'b1;
            p2_r    <= fwd1(p2_r);
            state_r <= B_M_CHK;
          end else begin
            guard_r <= guard_r + 1'b1;
            state_r <= B_M_LOOP;
          end
        end

        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/command_history_store.sv
// ----------------------------------------------------------------------------
// command_history_store
// Ring store of zero-terminated command lines with add, get, step and
// prefix match requests.
//
//   channel  direction  payload  transfer when
//   in_      input      in_t     in_valid && !in_stall
//   out_     output     out_t    out_valid && !out_stall
//
// After reset all STORE_BYTES bytes of the store are cleared one byte a
// cycle, with in_stall high. Line and pattern bytes are gathered into the
// line buffer as they are accepted. A command then runs in the back end
// sequencer, which for each store byte visited does a registered memory
// read, a decision and, in the shift, append and compare loops, a bound
// check. Get emits its copied bytes one result at a time and waits while
// the output is stalled. Streaming items stall while the previous line is
// still in use; other requests queue in a two-entry command queue.
// ----------------------------------------------------------------------------
module command_history_store
  import chs_pkg::*;
#(
  parameter int STORE_BYTES = CHS_STORE_BYTES,
  parameter int MAX_LINE    = CHS_MAX_LINE,
  localparam int LINE_CAP   = (MAX_LINE < STORE_BYTES - 2) ? MAX_LINE : STORE_BYTES - 2,
  localparam int LW         = $clog2(LINE_CAP + 1),
  localparam int LI         = $clog2(MAX_LINE)
)(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  bk_stat_t      bk_stat;
  logic          fifo_full;
  logic          fifo_empty;
  logic          fifo_push;
  logic          fifo_pop;
  cmd_t          push_data;
  cmd_t          pop_data;
  logic [LW-1:0] buf_len;
  logic [LI-1:0] lb_rd_addr;
  logic [7:0]    lb_rd_data;

  chs_front #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .bk_stat   (bk_stat),
    .fifo_full (fifo_full),
    .fifo_push (fifo_push),
    .fifo_data (push_data),
    .buf_len   (buf_len),
    .lb_rd_addr(lb_rd_addr),
    .lb_rd_data(lb_rd_data)
  );

  chs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(push_data),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_data (pop_data),
    .empty    (fifo_empty)
  );

  chs_back #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_LINE   (MAX_LINE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_empty(fifo_empty),
    .fifo_data (pop_data),
    .fifo_pop  (fifo_pop),
    .buf_len   (buf_len),
    .lb_rd_addr(lb_rd_addr),
    .lb_rd_data(lb_rd_data),
    .bk_stat   (bk_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
